/* src/sere_pkg.sv */
// Shared types and constants of the SPI EEPROM read emulator.
`default_nettype none

package sere_pkg;

	localparam int IMAGE_DEPTH_DEF = 65536;

	localparam int ADDR_W = 16;
	localparam int LEN_W  = 17;
	localparam int ERR_W  = 8;
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 17;

	localparam logic [BYTE_W-1:0] READ_CMD    = 8'h03;
	localparam logic [ERR_W-1:0]  ERR_SAT     = 8'hff;
	localparam logic [ERR_W-1:0]  LIMIT_RESET = 8'd100;

	// Register indexes of the configuration port.
	localparam logic REG_IMAGE_LENGTH = 1'b0;
	localparam logic REG_ERROR_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_START   = 2'd1,
		ACT_RX      = 2'd2,
		ACT_TIMEOUT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_CMD  = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	typedef struct packed {
		action_t             action;
		logic [ADDR_W-1:0]   load_address;
		logic [BYTE_W-1:0]   load_data;
		logic [BYTE_W-1:0]   rx_byte;
	} item_t;

	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [BYTE_W-1:0]   wdata;
		logic                re;
		logic [ADDR_W-1:0]   raddr;
	} mem_req_t;

	typedef struct packed {
		logic tx_valid;
		logic done_res;
		logic success;
	} res_t;

endpackage

`default_nettype wire

/* src/spi_eeprom_read_emulator_unit.sv */
// Top level of the SPI EEPROM read emulator: handshake pipeline and image RAM.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tuser action, s_tdata load/rx fields
//  m_*      out  m_tvalid / m_tready    m_tuser tx_valid, m_tdata tx/status
//  cfg_*    in   cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while m_tready holds; an item passes from input
// transfer to result through the input register and then the result register,
// whose image byte comes out of the registered read port of the image RAM.
// Reset clears the boot state to finished and the registers to their
// defaults; the image RAM is not cleared and holds garbage until loaded.
// A stalled result holds while the input register can still take one item.
`default_nettype none

module spi_eeprom_read_emulator_unit #(
	parameter int IMAGE_DEPTH = sere_pkg::IMAGE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// tdata: load_address[15:0], load_data[23:16], rx_byte[31:24]
	input  wire logic [31:0]                s_tdata,
	// tuser: action[1:0]
	input  wire logic [1:0]                 s_tuser,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// tdata: tx_byte[7:0], done_res[8], success[9], zero[15:10]
	output logic [15:0]                     m_tdata,
	// tuser: tx_valid[0]
	output logic                            m_tuser,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [sere_pkg::CFG_W-1:0] cfg_data
);

	localparam int RAM_AW = $clog2(IMAGE_DEPTH);

	sere_pkg::item_t    item_s1;
	logic               valid_s1;
	sere_pkg::res_t     res_s2, res_comb;
	logic               valid_s2;
	sere_pkg::mem_req_t mem;
	logic [7:0]         rdata;
	logic               s2_free;
	logic               fire;

	// Advance s1 into s2 whenever the result slot is empty or being taken.
	assign s2_free  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture the input fields on every transfer.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action       <= sere_pkg::action_t'(s_tuser);
			item_s1.load_address <= s_tdata[15:0];
			item_s1.load_data    <= s_tdata[23:16];
			item_s1.rx_byte      <= s_tdata[31:24];
		end
	end

	sere_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.mem       (mem),
		.res       (res_comb)
	);

	// Load writes and boot reads share the same stage, so a byte loaded by
	// one item is seen by a read of the next.
	sere_ram #(
		.WIDTH (8),
		.DEPTH (IMAGE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr[RAM_AW-1:0]),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr[RAM_AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	// Drop the RAM data when no byte was read for this result.
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.tx_valid;
	assign m_tdata  = {6'd0, res_s2.success, res_s2.done_res,
	                   res_s2.tx_valid ? rdata : 8'h00};

endmodule

`default_nettype wire

/* src/sere_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sere_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold the read data unless a new read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/sere_ctrl.sv */
// Boot state, configuration registers and per-item step logic.
`default_nettype none

module sere_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [sere_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          fire,
	input  wire sere_pkg::item_t               item,
	output sere_pkg::mem_req_t                 mem,
	output sere_pkg::res_t                     res
);

	logic [sere_pkg::LEN_W-1:0]  image_length_q;
	logic [sere_pkg::ERR_W-1:0]  error_limit_q;

	sere_pkg::phase_t            phase_q, phase_n;
	logic [sere_pkg::ADDR_W-1:0] read_address_q, read_address_n, addr_step;
	logic                        address_valid_q, address_valid_n;
	logic [sere_pkg::ERR_W-1:0]  error_count_q, error_count_n;
	logic                        finished_q, finished_n;
	logic                        complete;
	logic                        tx_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= '0;
			error_limit_q  <= sere_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sere_pkg::REG_IMAGE_LENGTH: image_length_q <= cfg_data;
				sere_pkg::REG_ERROR_LIMIT:  error_limit_q  <= cfg_data[sere_pkg::ERR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= sere_pkg::PH_CMD;
			read_address_q  <= '0;
			address_valid_q <= 1'b0;
			error_count_q   <= '0;
			finished_q      <= 1'b1;
		end else if (fire) begin
			phase_q         <= phase_n;
			read_address_q  <= read_address_n;
			address_valid_q <= address_valid_n;
			error_count_q   <= error_count_n;
			finished_q      <= finished_n;
		end
	end

	always_comb begin
		phase_n         = phase_q;
		addr_step       = read_address_q;
		address_valid_n = address_valid_q;
		error_count_n   = error_count_q;
		finished_n      = finished_q;
		complete        = 1'b0;
		tx_valid        = 1'b0;
		read_address_n  = read_address_q;

		unique case (item.action)
			sere_pkg::ACT_LOAD: ;
			sere_pkg::ACT_START: begin
				phase_n         = sere_pkg::PH_CMD;
				addr_step       = '0;
				address_valid_n = 1'b0;
				error_count_n   = '0;
				finished_n      = 1'b0;
			end
			sere_pkg::ACT_RX: begin
				if (!finished_q) begin
					unique case (phase_q)
						sere_pkg::PH_HIGH: begin
							addr_step = {item.rx_byte, 8'h00};
							phase_n   = sere_pkg::PH_LOW;
						end
						sere_pkg::PH_LOW: begin
							addr_step       = read_address_q | {8'h00, item.rx_byte};
							address_valid_n = 1'b1;
							phase_n         = sere_pkg::PH_CMD;
							complete        = 1'b1;
						end
						default: begin
							if (item.rx_byte == sere_pkg::READ_CMD) begin
								phase_n = sere_pkg::PH_HIGH;
							end else begin
								complete = 1'b1;
							end
						end
					endcase
				end
			end
			default: begin
				if (!finished_q) begin
					if (phase_q == sere_pkg::PH_CMD &&
					    error_count_q != sere_pkg::ERR_SAT) begin
						error_count_n = error_count_q + 8'd1;
					end
					phase_n  = sere_pkg::PH_CMD;
					complete = 1'b1;
				end
			end
		endcase

		read_address_n = addr_step;
		if (complete) begin
			if ({1'b0, addr_step} >= image_length_q || error_count_n >= error_limit_q) begin
				finished_n = 1'b1;
			end else if (address_valid_n) begin
				tx_valid       = 1'b1;
				read_address_n = addr_step + 16'd1;
			end
		end
	end

	always_comb begin
		mem.we    = fire && (item.action == sere_pkg::ACT_LOAD);
		mem.waddr = item.load_address;
		mem.wdata = item.load_data;
		mem.re    = fire && tx_valid;
		mem.raddr = addr_step;

		res.tx_valid = tx_valid;
		res.done_res = finished_n;
		res.success  = finished_n && (error_count_n < error_limit_q);
	end

endmodule

`default_nettype wire

/* src/sere_chk.sv */
// Port-level checker for the SPI EEPROM read emulator, bound to the top level.
`default_nettype none

module sere_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tuser
);

	// A byte is only sent while the boot is still running.
	a_tx_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[8])
		else $error("transmit byte reported on a finished boot");

	a_success_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8])
		else $error("success reported while not done");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00 && m_tdata[15:10] == 6'd0)
		else $error("result byte or padding not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind spi_eeprom_read_emulator_unit sere_chk u_sere_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
